[hw/rtl/dpt_pkg.sv]
// Package for the decimal prime test device.
// Holds the item structs, the controller/datapath command and status structs,
// the controller state type and the shared constants. Depends on nothing.
package dpt_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);
  localparam int SQ_WIDTH     = NUMBER_WIDTH + 2;

  localparam logic       OP_WRITE   = 1'b0;
  localparam logic       OP_READ    = 1'b1;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [5:0] REPLY_ZERO = 6'd48;
  localparam logic [5:0] REPLY_ONE  = 6'd49;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic       first_of_write;
    logic       last_of_write;
  } in_item_t;

  typedef struct packed {
    logic [5:0] reply_char;
    logic       is_prime;
  } out_item_t;

  typedef struct packed {
    logic acc_write;
    logic load_test;
    logic div_start;
    logic div_step;
    logic next_div;
    logic reply_en;
    logic verdict;
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_lt4;
    logic n_even;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
  } dp_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_TEST
  } state_t;

endpackage

[hw/rtl/decimal_prime_test_device.sv]
// Top level of the decimal prime test device: controller and datapath.
// Depends on dpt_pkg, dpt_controller and dpt_datapath.
//
//   Channel  Ports                        Transfer
//   input    start, busy, in_item         start high while busy low
//   result   out_valid, out_item          out_valid high for one cycle
//
// A write item updates the accumulator and the block stays ready. A read of a value
// below 4 or an even value answers in the cycle after acceptance. Otherwise odd
// divisors are tried from 3 with busy high, each via ST_CHECK, ST_DIV and ST_TEST;
// the first exact divisor ends the test, and a square past the value ends it prime.
// Reset is synchronous and active low and clears the accumulator and stored number.
// The result strobe cannot be stalled by the receiver.
module decimal_prime_test_device (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dpt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dpt_pkg::out_item_t out_item
);
  import dpt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dpt_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  dpt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[hw/rtl/dpt_datapath.sv]
// Datapath of the decimal prime test device: digit accumulator, stored number,
// trial divisor with its square, a bit-serial remainder unit and the result register.
// Depends on dpt_pkg.
module dpt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dpt_pkg::in_item_t  in_item,
  input  dpt_pkg::dp_cmd_t   cmd,
  output dpt_pkg::dp_sts_t   sts,
  output logic               out_valid,
  output dpt_pkg::out_item_t out_item
);
  import dpt_pkg::*;

  logic [NUMBER_WIDTH-1:0] acc_r, acc_nxt;
  logic [NUMBER_WIDTH-1:0] num_r, num_nxt;
  logic [NUMBER_WIDTH-1:0] div_r, div_nxt;
  logic [SQ_WIDTH-1:0]     sq_r, sq_nxt;
  logic [NUMBER_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUMBER_WIDTH-1:0] shf_r, shf_nxt;
  logic [CNT_WIDTH-1:0]    cnt_r, cnt_nxt;
  logic                    out_valid_r;
  out_item_t               out_item_r, out_item_nxt;

  logic [NUMBER_WIDTH-1:0] acc_base;
  logic [NUMBER_WIDTH-1:0] acc_fold;
  logic [NUMBER_WIDTH:0]   rem_sh;
  logic                    rem_ge;

  assign acc_base = in_item.first_of_write ? '0 : acc_r;
  assign acc_fold = (acc_base << 3) + (acc_base << 1)
                  + {{(NUMBER_WIDTH-8){1'b0}}, in_item.data_byte}
                  - {{(NUMBER_WIDTH-8){1'b0}}, ASCII_ZERO};

  assign rem_sh = {rem_r, shf_r[NUMBER_WIDTH-1]};
  assign rem_ge = rem_sh >= {1'b0, div_r};

  always_comb begin
    acc_nxt      = acc_r;
    num_nxt      = num_r;
    div_nxt      = div_r;
    sq_nxt       = sq_r;
    rem_nxt      = rem_r;
    shf_nxt      = shf_r;
    cnt_nxt      = cnt_r;
    out_item_nxt = out_item_r;
    if (cmd.acc_write) begin
      if (in_item.last_of_write) begin
        acc_nxt = acc_base;
        num_nxt = acc_base;
      end else begin
        acc_nxt = acc_fold;
      end
    end
    if (cmd.load_test) begin
      div_nxt = NUMBER_WIDTH'(3);
      sq_nxt  = SQ_WIDTH'(9);
    end
    if (cmd.next_div) begin
      div_nxt = div_r + NUMBER_WIDTH'(2);
      sq_nxt  = sq_r + ({2'b00, div_r} << 2) + SQ_WIDTH'(4);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      shf_nxt = num_r;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = rem_ge ? NUMBER_WIDTH'(rem_sh - {1'b0, div_r}) : rem_sh[NUMBER_WIDTH-1:0];
      shf_nxt = shf_r << 1;
      cnt_nxt = cnt_r + CNT_WIDTH'(1);
    end
    if (cmd.reply_en) begin
      out_item_nxt.reply_char = cmd.verdict ? REPLY_ONE : REPLY_ZERO;
      out_item_nxt.is_prime   = cmd.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      num_r       <= num_nxt;
      out_valid_r <= cmd.reply_en;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    shf_r      <= shf_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    sts.n_lt2    = num_r < NUMBER_WIDTH'(2);
    sts.n_lt4    = num_r < NUMBER_WIDTH'(4);
    sts.n_even   = ~num_r[0];
    sts.sq_gt_n  = sq_r > {2'b00, num_r};
    sts.div_last = cnt_r == CNT_WIDTH'(NUMBER_WIDTH - 1);
    sts.rem_zero = rem_r == '0;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hw/rtl/dpt_controller.sv]
// Controller state machine of the decimal prime test device.
// Sequences writes, the small-value checks and the trial division loop.
// Depends on dpt_pkg.
module dpt_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             opcode,
  input  dpt_pkg::dp_sts_t sts,
  output dpt_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import dpt_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = state_r != ST_IDLE;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && opcode == OP_READ && !sts.n_lt4 && !sts.n_even) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.sq_gt_n ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        state_nxt = sts.rem_zero ? ST_IDLE : ST_CHECK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && opcode == OP_WRITE) begin
          cmd.acc_write = 1'b1;
        end
        if (accept && opcode == OP_READ) begin
          if (sts.n_lt2) begin
            cmd.reply_en = 1'b1;
            cmd.verdict  = 1'b0;
          end else if (sts.n_lt4) begin
            cmd.reply_en = 1'b1;
            cmd.verdict  = 1'b1;
          end else if (sts.n_even) begin
            cmd.reply_en = 1'b1;
            cmd.verdict  = 1'b0;
          end else begin
            cmd.load_test = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (sts.sq_gt_n) begin
          cmd.reply_en = 1'b1;
          cmd.verdict  = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_TEST: begin
        if (sts.rem_zero) begin
          cmd.reply_en = 1'b1;
          cmd.verdict  = 1'b0;
        end else begin
          cmd.next_div = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
